// ===== hdl/min_cost_volume_cover_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expects clk and rst in scope
`ifndef MIN_COST_VOLUME_COVER_MACROS_SVH
`define MIN_COST_VOLUME_COVER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define MCVC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// property that must hold in the cycle after its trigger
`define MCVC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/mcvc_pkg.sv =====
// shared types and constants for the min cost volume cover block
// no dependencies
package mcvc_pkg;

  localparam int MAX_ITEMS   = 128;
  localparam int ITEM_AW     = $clog2(MAX_ITEMS);
  localparam int COUNT_W     = ITEM_AW + 1;
  localparam int PRICE_W     = 16;
  localparam int VOL_W       = 11;
  localparam int COST_W      = 28;
  localparam int MINCOST_W   = 27;
  localparam int TABLE_DEPTH = 2049;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);

  localparam logic [VOL_W-1:0]  MAX_TARGET = VOL_W'(1024);
  localparam logic [VOL_W-1:0]  MAX_VOLUME = VOL_W'(1024);
  localparam logic [COST_W-1:0] COST_INF   = {COST_W{1'b1}};
  localparam logic [VOL_W-1:0]  CFG_RESET  = VOL_W'(1);

  typedef struct packed {
    logic [PRICE_W-1:0] item_price;
    logic [VOL_W-1:0]   item_volume;
    logic               last_item;
  } item_t;

  typedef struct packed {
    logic [MINCOST_W-1:0] min_cost;
    logic                 no_solution;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ITEM_RD,
    S_COST_RD,
    S_ACC,
    S_WRITE,
    S_SCAN_RD,
    S_SCAN_ACC
  } state_t;

  // sequencer commands to the cost table and min unit
  typedef struct packed {
    logic              wr_en;
    logic              wr_zero;
    logic [TAB_AW-1:0] wr_addr;
    logic              rd_en;
    logic [TAB_AW-1:0] rd_addr;
    logic              acc_clear;
    logic              acc_add;
    logic              acc_scan;
  } ctl_t;

endpackage

// ===== hdl/mcvc_cost_unit.sv =====
// cost table memory with the shared add and compare unit
// depends on mcvc_pkg
module mcvc_cost_unit
  import mcvc_pkg::*;
(
  input  logic               clk,
  input  ctl_t               ctl,
  input  logic [PRICE_W-1:0] price,
  output logic [COST_W-1:0]  acc
);

  logic [COST_W-1:0] mem [TABLE_DEPTH];
  logic [COST_W-1:0] rd_data;
  logic [COST_W-1:0] cand;
  logic              take;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_zero ? '0 : acc;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  // shared adder and compare
  always_comb begin
    cand = ctl.acc_add ? (rd_data + COST_W'(price)) : rd_data;
    take = (ctl.acc_add || ctl.acc_scan) && (rd_data != COST_INF) && (cand < acc);
  end

  // running minimum
  always_ff @(posedge clk) begin
    if (ctl.acc_clear) begin
      acc <= COST_INF;
    end else if (take) begin
      acc <= cand;
    end
  end

endmodule

// ===== hdl/min_cost_volume_cover.sv =====
// top level of the min cost volume cover block: item stores and sequencer
// depends on mcvc_pkg and mcvc_cost_unit
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+----------
//   item      | in        | item_valid / stall   | item_t
//   result    | out       | result_valid / stall | result_t
//   cfg       | in        | cfg_wr_en            | 11 bit target
//
// an item without last_item is stored if its volume is 1 to 1024 and the store
// has room; item_stall stays low. a last item with items stored starts the
// table fill over totals 1 to T + V, T target, V largest volume, through the
// cost table and the shared add and compare unit, then one result
// that waits for a free output register; rst is synchronous, clears the item
// count and the output valid and sets the target register to 1
module min_cost_volume_cover
  import mcvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_wr_en,
  input  logic [VOL_W-1:0] cfg_wr_data
);

  state_t state, state_next;
  ctl_t   ctl;

  logic [VOL_W-1:0]   target_cfg;
  logic [VOL_W-1:0]   tgt_q;
  logic [TAB_AW-1:0]  last_q;
  logic [TAB_AW-1:0]  idx;
  logic [ITEM_AW-1:0] j;
  logic [COUNT_W-1:0] count;
  logic [VOL_W-1:0]   maxv;
  logic               use_q;

  logic [PRICE_W-1:0] price_mem [MAX_ITEMS];
  logic [VOL_W-1:0]   vol_mem [MAX_ITEMS];
  logic [PRICE_W-1:0] price_q;
  logic [VOL_W-1:0]   vol_q;

  logic               accept;
  logic               store_ok;
  logic [COUNT_W-1:0] count_next;
  logic [VOL_W-1:0]   maxv_next;
  logic [VOL_W-1:0]   tgt_sat;
  logic               j_last;
  logic               vol_fits;
  logic               out_free;
  logic               finish;
  logic [COST_W-1:0]  acc;

  // item transaction decode
  always_comb begin
    accept     = item_valid && !item_stall;
    store_ok   = (item.item_volume != '0) && (item.item_volume <= MAX_VOLUME) &&
                 (count < COUNT_W'(MAX_ITEMS));
    count_next = (accept && store_ok) ? count + 1'b1 : count;
    maxv_next  = (accept && store_ok && item.item_volume > maxv) ? item.item_volume : maxv;
    tgt_sat    = (target_cfg > MAX_TARGET) ? MAX_TARGET : target_cfg;
    j_last     = (COUNT_W'(j) + 1'b1) == count;
    vol_fits   = TAB_AW'(vol_q) <= idx;
    out_free   = !result_valid || !result_stall;
    finish     = (state == S_SCAN_ACC) && (idx == last_q) && out_free;
  end

  assign item_stall = (state != S_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      target_cfg <= cfg_wr_data;
    end
  end

  // item stores, written while idle and read one entry per step
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      price_mem[count[ITEM_AW-1:0]] <= item.item_price;
      vol_mem[count[ITEM_AW-1:0]]   <= item.item_volume;
    end
    if (state == S_ITEM_RD) begin
      price_q <= price_mem[j];
      vol_q   <= vol_mem[j];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && item.last_item) begin
          state_next = (count_next == '0) ? S_SCAN_ACC : S_INIT;
        end
      end
      S_INIT:    state_next = S_ITEM_RD;
      S_ITEM_RD: state_next = S_COST_RD;
      S_COST_RD: state_next = S_ACC;
      S_ACC:     state_next = j_last ? S_WRITE : S_ITEM_RD;
      S_WRITE:   state_next = (idx == last_q) ? S_SCAN_RD : S_ITEM_RD;
      S_SCAN_RD: state_next = S_SCAN_ACC;
      S_SCAN_ACC: begin
        if (idx != last_q) begin
          state_next = S_SCAN_RD;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // commands to the cost unit
  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE: begin
        ctl.acc_clear = accept && item.last_item;
      end
      S_INIT: begin
        ctl.wr_en     = 1'b1;
        ctl.wr_zero   = 1'b1;
        ctl.acc_clear = 1'b1;
      end
      S_COST_RD: begin
        ctl.rd_en   = vol_fits;
        ctl.rd_addr = idx - TAB_AW'(vol_q);
      end
      S_ACC: begin
        ctl.acc_add = use_q;
      end
      S_WRITE: begin
        ctl.wr_en     = 1'b1;
        ctl.wr_addr   = idx;
        ctl.acc_clear = 1'b1;
      end
      S_SCAN_RD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = idx;
      end
      S_SCAN_ACC: begin
        // empty set arrives here with no read done, so leave acc alone
        ctl.acc_scan = (count != '0);
      end
      default: ctl = '0;
    endcase
  end

  // counters and set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      maxv  <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        count <= '0;
        maxv  <= '0;
      end else begin
        count <= count_next;
        maxv  <= maxv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tgt_q  <= tgt_sat;
        last_q <= TAB_AW'(tgt_sat) + TAB_AW'(maxv_next);
        idx    <= (count_next == '0) ? TAB_AW'(tgt_sat) + TAB_AW'(maxv_next) : '0;
      end
      S_INIT: begin
        idx <= TAB_AW'(1);
        j   <= '0;
      end
      S_COST_RD: use_q <= vol_fits;
      S_ACC:     j <= j + 1'b1;
      S_WRITE: begin
        j   <= '0;
        idx <= (idx == last_q) ? TAB_AW'(tgt_q) : idx + 1'b1;
      end
      S_SCAN_ACC: begin
        if (idx != last_q) begin
          idx <= idx + 1'b1;
        end
      end
      default: idx <= idx;
    endcase
  end

  mcvc_cost_unit u_cost (
    .clk   (clk),
    .ctl   (ctl),
    .price (price_q),
    .acc   (acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.no_solution <= (acc == COST_INF);
      result.min_cost    <= (acc == COST_INF) ? '0 : acc[MINCOST_W-1:0];
    end
  end

endmodule

// ===== hdl/mcvc_checker.sv =====
// port level checks for the min cost volume cover block, bound to the top
// depends on mcvc_pkg, min_cost_volume_cover_macros.svh and the top level
`include "min_cost_volume_cover_macros.svh"

module mcvc_checker
  import mcvc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a held result keeps its value
  `MCVC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // no cover always reports a zero cost
  `MCVC_ASSERT_NOW(a_nosol_zero, result_valid && result.no_solution, result.min_cost == '0)

  // a last item starts the busy phase
  `MCVC_ASSERT_NEXT(a_last_busy, item_valid && !item_stall && item.last_item, item_stall)

  // a plain item never stalls the next transaction
  `MCVC_ASSERT_NEXT(a_plain_free, item_valid && !item_stall && !item.last_item, !item_stall)

  // a new result only comes out of a busy phase
  `MCVC_ASSERT_NOW(a_result_after_busy, $rose(result_valid), $past(item_stall))

endmodule

bind min_cost_volume_cover mcvc_checker u_chk (.*);

// ===== tb/tb_min_cost_volume_cover.sv =====
// self-checking testbench for min_cost_volume_cover: directed, full-store, backpressure and
// random item sets checked against an in-bench cheapest-cover predictor; uses mcvc_pkg and the top level
module tb_min_cost_volume_cover;
  import mcvc_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_SPARSE,
    RX_CHOPPY,
    RX_PERIODIC
  } rx_mode_t;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  item_t            item;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_wr_en;
  logic [VOL_W-1:0] cfg_wr_data;

  min_cost_volume_cover dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // predictor state: stored item kinds, target and cost table
  logic [PRICE_W-1:0] kind_price  [MAX_ITEMS];
  logic [VOL_W-1:0]   kind_volume [MAX_ITEMS];
  int unsigned        kind_count;
  int unsigned        widest_volume;
  logic [VOL_W-1:0]   goal_volume;
  logic [COST_W-1:0]  cover_cost  [TABLE_DEPTH];
  result_t            pending_covers [$];

  // run bookkeeping
  int          mismatches;
  int unsigned items_sent;
  int unsigned sets_sent;
  int unsigned covers_checked;
  int unsigned burst_left;
  bit          steady_send;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned rx_left;
  int unsigned rx_cycle;
  rx_mode_t    rx_mode;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

  // cheapest cover over all totals from the saturated goal upward
  function automatic result_t cheapest_cover();
    int unsigned goal, span, best, cur, c, t, j;
    result_t     r;
    goal = 32'(goal_volume);
    if (goal > 32'(MAX_TARGET)) goal = 32'(MAX_TARGET);
    span = goal + widest_volume + 1;
    cover_cost[0] = '0;
    for (t = 1; t < span; t++) begin
      cur = 32'(COST_INF);
      for (j = 0; j < kind_count; j++) begin
        if (kind_volume[j] <= t && cover_cost[t - kind_volume[j]] != COST_INF) begin
          c = 32'(cover_cost[t - kind_volume[j]]) + 32'(kind_price[j]);
          if (c < cur) cur = c;
        end
      end
      cover_cost[t] = cur[COST_W-1:0];
    end
    best = 32'(COST_INF);
    for (t = goal; t < span; t++)
      if (cover_cost[t] < best) best = 32'(cover_cost[t]);
    if (kind_count == 0 || best == COST_INF) begin
      r.min_cost    = '0;
      r.no_solution = 1'b1;
    end else begin
      r.min_cost    = best[MINCOST_W-1:0];
      r.no_solution = 1'b0;
    end
    return r;
  endfunction

  // update the predictor with one accepted item transaction
  task automatic absorb_item(input item_t it);
    result_t next_cover;
    if (it.item_volume >= 1 && it.item_volume <= MAX_VOLUME && kind_count < MAX_ITEMS) begin
      kind_price[kind_count]  = it.item_price;
      kind_volume[kind_count] = it.item_volume;
      kind_count++;
      if (it.item_volume > widest_volume) widest_volume = 32'(it.item_volume);
    end
    if (it.last_item) begin
      next_cover     = cheapest_cover();
      pending_covers = {pending_covers, next_cover};
      kind_count    = 0;
      widest_volume = 0;
      sets_sent++;
    end
  endtask

  // offer one item; valid stays high on return so a following item needs no bubble
  task automatic offer_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    absorb_item(it);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding cover plus a short settle
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_covers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // target register write; only called with the block idle
  task automatic write_target(input int unsigned value);
    cfg_wr_data <= VOL_W'(value);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    goal_volume = VOL_W'(value);
  endtask

  function automatic item_t make_item(input int unsigned price, input int unsigned vol,
                                      input bit last);
    item_t it;
    it.item_price  = PRICE_W'(price);
    it.item_volume = VOL_W'(vol);
    it.last_item   = last;
    return it;
  endfunction

  // random well-formed item, prices biased toward the extremes now and then
  function automatic item_t random_item(input int unsigned vol_hi, input bit last);
    int unsigned pick, price;
    pick  = $urandom_range(0, 9);
    price = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 65535);
    return make_item(price, $urandom_range(1, vol_hi), last);
  endfunction

  // item the block must ignore: zero or oversized volume
  function automatic item_t noise_item(input bit last);
    int unsigned vol;
    vol = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
    return make_item($urandom_range(0, 65535), vol, last);
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      covers_checked++;
      if (pending_covers.size() == 0) begin
        $display("%0t unexpected result transaction: min_cost %0d no_solution %0b",
                 $realtime, result.min_cost, result.no_solution);
        mismatches++;
      end else begin
        want = pending_covers.pop_front();
        if (result.min_cost !== want.min_cost) begin
          $display("%0t min_cost mismatch: expected %0d actual %0d",
                   $realtime, want.min_cost, result.min_cost);
          mismatches++;
        end
        if (result.no_solution !== want.no_solution) begin
          $display("%0t no_solution mismatch: expected %0b actual %0b",
                   $realtime, want.no_solution, result.no_solution);
          mismatches++;
        end
      end
    end
    rx_cycle++;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = 2500;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   result_stall <= 1'b0;
        RX_SPARSE: result_stall <= ($urandom_range(0, 3) == 0);
        RX_CHOPPY: result_stall <= 1'($urandom_range(0, 1));
        default:   result_stall <= ((rx_cycle % 8) < 5);
      endcase
    end
  end

  // extremes of every field, ignored volumes, empty sets and target extremes
  task automatic test_directed();
    // reset target of one
    offer_item(make_item(0, 0, 1'b1));
    offer_item(make_item(0, 1, 1'b1));
    offer_item(make_item(65535, 1, 1'b0));
    offer_item(make_item(10, 2, 1'b1));
    settle();
    // largest legal target
    write_target(32'(MAX_TARGET));
    offer_item(make_item(65535, 1, 1'b1));
    offer_item(make_item(65535, 1024, 1'b0));
    offer_item(make_item(1, 0, 1'b0));
    offer_item(make_item(2, 1025, 1'b0));
    offer_item(make_item(3, 2047, 1'b0));
    offer_item(make_item(40000, 1000, 1'b1));
    settle();
    // target above the limit saturates
    write_target(2047);
    offer_item(make_item(100, 1023, 1'b0));
    offer_item(make_item(1, 2, 1'b0));
    offer_item(make_item(65535, 1024, 1'b1));
    settle();
    // zero target: empty cover counts once something is stored
    write_target(0);
    offer_item(make_item(5, 7, 1'b0));
    offer_item(make_item(9, 3, 1'b1));
    offer_item(make_item(77, 0, 1'b1));
    settle();
    // ignored last item still starts the fill
    write_target(1);
    offer_item(make_item(0, 1024, 1'b0));
    offer_item(make_item(12, 0, 1'b1));
    settle();
  endtask

  // more kinds than the store holds; the late cheap ones must be dropped
  task automatic test_full_store();
    int i;
    write_target(5);
    for (i = 0; i < 140; i++) begin
      if (i >= MAX_ITEMS) offer_item(make_item(0, 1, i == 139));
      else offer_item(random_item(6, 1'b0));
    end
    settle();
  endtask

  // long receiver hold while sets keep coming, so the block stalls its input
  task automatic test_backpressure();
    int s, i;
    write_target(3);
    steady_send  = 1'b1;
    hold_request = 1'b1;
    for (s = 0; s < 5; s++)
      for (i = 0; i < 3; i++) offer_item(random_item(3, i == 2));
    settle();
    steady_send = 1'b0;
  endtask

  // one random set; short sets keep large targets and wide volumes affordable
  task automatic send_random_set(input bit short_set, inout int unsigned stored);
    int unsigned len, vol_hi, i, pick;
    item_t       it;
    pick = $urandom_range(0, 19);
    if (short_set) begin
      len    = $urandom_range(1, 3);
      vol_hi = 24;
    end else if (pick == 0) begin
      len    = $urandom_range(1, 4);
      vol_hi = MAX_VOLUME;
    end else begin
      len    = $urandom_range(1, 20);
      vol_hi = 24;
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) it = noise_item(i == len - 1);
      else it = random_item(vol_hi, i == len - 1);
      if (it.item_volume != 0 && it.item_volume <= MAX_VOLUME) stored++;
      offer_item(it);
    end
  endtask

  // phases of random sets, each with its own target and sender behavior
  task automatic test_random_sets();
    int unsigned stored, sets, target;
    bit          wide_phase;
    stored = 0;
    while (stored < 1240) begin
      settle();
      wide_phase = ($urandom_range(0, 4) == 0);
      target     = wide_phase ? $urandom_range(0, 2047) : $urandom_range(0, 40);
      write_target(target);
      steady_send = ($urandom_range(0, 3) == 0);
      sets        = wide_phase ? 2 : $urandom_range(3, 10);
      repeat (sets) send_random_set(wide_phase, stored);
    end
    settle();
  endtask

  // stimulus sequence
  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    kind_count    = 0;
    widest_volume = 0;
    goal_volume   = CFG_RESET;
    mismatches    = 0;
    items_sent    = 0;
    sets_sent     = 0;
    covers_checked = 0;
    burst_left    = 0;
    steady_send   = 1'b0;
    hold_request  = 1'b0;
    hold_left     = 0;
    rx_left       = 0;
    rx_cycle      = 0;
    rx_mode       = RX_OPEN;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_store();
    test_backpressure();
    test_random_sets();

    settle();
    repeat (50) @(posedge clk);
    if (pending_covers.size() != 0) begin
      $display("%0t %0d expected results never arrived", $realtime, pending_covers.size());
      mismatches++;
    end
    $display("covered %0d item transactions in %0d sets, %0d results checked, %0d mismatches",
             items_sent, sets_sent, covers_checked, mismatches);
    $display("targets 0 to 2047, full store, ignored volumes, long output hold");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
